>>> hdl/spflf_pkg.sv
// Shared constants for the start-pattern fixed-length framer.
// Holds the configuration register indexes; depends on nothing.
`default_nettype none

package spflf_pkg;

	localparam int CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] REG_RECEIVE_ENABLE  = 3'd0;
	localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH  = 3'd1;
	localparam logic [CFG_IDX_W-1:0] REG_START_PATTERN   = 3'd2;
	localparam logic [CFG_IDX_W-1:0] REG_SENTENCE_LENGTH = 3'd3;

endpackage

`default_nettype wire

>>> hdl/start_pattern_fixed_length_framer.sv
// Sequencing: a byte that does not fill the window leaves the sequencer idle. A full window
// steps through a read and a check state per compared pattern byte, then a read and a write
// state per emitted byte (the write state waits while out_stall holds), or on a mismatch (or
// a pattern longer than the sentence) a read and a check state per window byte scanned for
// the next start byte from the one-read-per-cycle window memory. in_stall is high while busy.
// Reset (arst_n low): window empty, receiving off, lengths 1, pattern 0; memory not cleared.
// Depends on spflf_pkg.
`default_nettype none

module start_pattern_fixed_length_framer
	import spflf_pkg::*;
#(
	parameter int MAX_SENTENCE = 64,
	parameter int MAX_PATTERN  = 8
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	// configuration write channel
	input  wire logic                 cfg_valid,
	output logic                      cfg_ready,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [63:0]          cfg_data,
	// received bytes
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire logic [7:0]           data_byte,
	input  wire logic [31:0]          rx_time,
	// sentence bytes
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output logic [7:0]                sentence_byte,
	output logic [31:0]               sentence_time,
	output logic [5:0]                byte_index,
	output logic                      last_byte
);

	localparam int ADDR_W = $clog2(MAX_SENTENCE);
	localparam int CNT_W  = $clog2(MAX_SENTENCE + 1);
	localparam int PIDX_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_CMP_RD,
		ST_CMP_CHK,
		ST_RS_RD,
		ST_RS_CHK,
		ST_EMIT_RD,
		ST_EMIT_WR
	} state_t;

	state_t state_q;

	logic             receive_enable_q;
	logic [3:0]       pattern_length_q;
	logic [7:0]       pattern_q [MAX_PATTERN];
	logic [6:0]       sentence_length_q;

	logic [CNT_W-1:0]  fill_q;
	logic [ADDR_W-1:0] head_q;
	logic [CNT_W-1:0]  idx_q;
	logic [31:0]       front_time_q;

	logic [7:0]  bytes_mem [MAX_SENTENCE];
	logic [31:0] times_mem [MAX_SENTENCE];
	logic [7:0]  rd_byte_q;
	logic [31:0] rd_time_q;

	logic              out_valid_q;
	logic [7:0]        sentence_byte_q;
	logic [31:0]       sentence_time_q;
	logic [5:0]        byte_index_q;
	logic              last_byte_q;

	logic [3:0]        plen_eff;
	logic [6:0]        slen_wide;
	logic [CNT_W-1:0]  slen_eff;
	logic              short_sentence;
	logic              cfg_wr;
	logic              in_acc;
	logic              wr_en;
	logic [ADDR_W-1:0] wr_addr;
	logic [ADDR_W-1:0] rd_addr;
	logic [7:0]        pat_cur;
	logic              out_free;
	logic              emit_fire;
	logic              cmp_last;
	logic              emit_last;

	// circular window address: base plus offset, both below the depth
	function automatic logic [ADDR_W-1:0] wrap_add(input logic [ADDR_W-1:0] base,
			input logic [CNT_W-1:0] off);
		logic [CNT_W:0] sum;
		sum = (CNT_W+1)'(base) + (CNT_W+1)'(off);
		if (sum >= (CNT_W+1)'(MAX_SENTENCE))
			sum = sum - (CNT_W+1)'(MAX_SENTENCE);
		return ADDR_W'(sum);
	endfunction

	always_comb begin
		if (pattern_length_q == 4'd0)
			plen_eff = 4'd1;
		else if (pattern_length_q > 4'(MAX_PATTERN))
			plen_eff = 4'(MAX_PATTERN);
		else
			plen_eff = pattern_length_q;
		if (sentence_length_q == 7'd0)
			slen_wide = 7'd1;
		else if (sentence_length_q > 7'(MAX_SENTENCE))
			slen_wide = 7'(MAX_SENTENCE);
		else
			slen_wide = sentence_length_q;
	end

	assign slen_eff       = CNT_W'(slen_wide);
	assign short_sentence = slen_wide < 7'(plen_eff);

	assign cfg_ready = 1'b1;
	assign cfg_wr    = cfg_valid;
	assign in_stall  = (state_q != ST_IDLE);
	assign in_acc    = in_valid && !in_stall;
	assign wr_en     = in_acc && receive_enable_q &&
		!(fill_q == '0 && data_byte != pattern_q[0]);
	assign wr_addr   = wrap_add(head_q, fill_q);
	assign rd_addr   = wrap_add(head_q, idx_q);
	assign pat_cur   = pattern_q[PIDX_W'(idx_q)];
	assign out_free  = !out_valid_q || !out_stall;
	assign emit_fire = !cfg_wr && (state_q == ST_EMIT_WR) && out_free;
	assign cmp_last  = (7'(idx_q) + 7'd1) == 7'(plen_eff);
	assign emit_last = (7'(idx_q) + 7'd1) == slen_wide;

	always_ff @(posedge clk) begin
		if (wr_en) begin
			bytes_mem[wr_addr] <= data_byte;
			times_mem[wr_addr] <= rx_time;
		end
		rd_byte_q <= bytes_mem[rd_addr];
		rd_time_q <= times_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q           <= ST_IDLE;
			receive_enable_q  <= 1'b0;
			pattern_length_q  <= 4'd1;
			for (int i = 0; i < MAX_PATTERN; i++)
				pattern_q[i] <= 8'd0;
			sentence_length_q <= 7'd1;
			fill_q            <= '0;
			head_q            <= '0;
			idx_q             <= '0;
			out_valid_q       <= 1'b0;
		end else begin
			if (emit_fire)
				out_valid_q <= 1'b1;
			else if (!out_stall)
				out_valid_q <= 1'b0;

			if (cfg_wr) begin
				case (cfg_index)
					REG_RECEIVE_ENABLE: begin
						receive_enable_q <= cfg_data[0];
					end
					REG_PATTERN_LENGTH: begin
						pattern_length_q <= cfg_data[3:0];
						fill_q           <= '0;
						state_q          <= ST_IDLE;
					end
					REG_START_PATTERN: begin
						for (int i = 0; i < MAX_PATTERN; i++)
							pattern_q[i] <= cfg_data[8*i +: 8];
						fill_q  <= '0;
						state_q <= ST_IDLE;
					end
					REG_SENTENCE_LENGTH: begin
						sentence_length_q <= cfg_data[6:0];
						fill_q            <= '0;
						state_q           <= ST_IDLE;
					end
					default: begin
					end
				endcase
			end else begin
				case (state_q)
					ST_IDLE: begin
						if (wr_en) begin
							if (fill_q == '0)
								front_time_q <= rx_time;
							fill_q <= fill_q + 1'b1;
							if (fill_q + 1'b1 == slen_eff) begin
								// full window: check pattern, or rescan if it cannot fit
								if (short_sentence) begin
									idx_q   <= CNT_W'(1);
									state_q <= ST_RS_RD;
								end else begin
									idx_q   <= '0;
									state_q <= ST_CMP_RD;
								end
							end
						end
					end
					ST_CMP_RD: begin
						state_q <= ST_CMP_CHK;
					end
					ST_CMP_CHK: begin
						if (rd_byte_q != pat_cur) begin
							idx_q   <= CNT_W'(1);
							state_q <= ST_RS_RD;
						end else if (cmp_last) begin
							idx_q   <= '0;
							state_q <= ST_EMIT_RD;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= ST_CMP_RD;
						end
					end
					ST_RS_RD: begin
						if (idx_q >= fill_q) begin
							fill_q  <= '0;
							state_q <= ST_IDLE;
						end else begin
							state_q <= ST_RS_CHK;
						end
					end
					ST_RS_CHK: begin
						// advance the front to the next first-pattern byte
						if (rd_byte_q == pattern_q[0]) begin
							head_q       <= wrap_add(head_q, idx_q);
							fill_q       <= fill_q - idx_q;
							front_time_q <= rd_time_q;
							state_q      <= ST_IDLE;
						end else begin
							idx_q   <= idx_q + 1'b1;
							state_q <= ST_RS_RD;
						end
					end
					ST_EMIT_RD: begin
						state_q <= ST_EMIT_WR;
					end
					ST_EMIT_WR: begin
						if (out_free) begin
							sentence_byte_q <= rd_byte_q;
							sentence_time_q <= front_time_q;
							byte_index_q    <= 6'(idx_q);
							last_byte_q     <= emit_last;
							if (emit_last) begin
								fill_q  <= '0;
								state_q <= ST_IDLE;
							end else begin
								idx_q   <= idx_q + 1'b1;
								state_q <= ST_EMIT_RD;
							end
						end
					end
					default: begin
						state_q <= ST_IDLE;
					end
				endcase
			end
		end
	end

	assign out_valid     = out_valid_q;
	assign sentence_byte = sentence_byte_q;
	assign sentence_time = sentence_time_q;
	assign byte_index    = byte_index_q;
	assign last_byte     = last_byte_q;

	a_idle_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) |-> (fill_q < slen_eff))
		else $error("window full while idle");

	a_busy_fill: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q != ST_IDLE) |-> (fill_q != '0))
		else $error("sequencer busy on an empty window");

	a_emit_full: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_EMIT_RD || state_q == ST_EMIT_WR || state_q == ST_CMP_CHK)
			|-> (fill_q == slen_eff))
		else $error("compare or emit without a full window");

	a_head_range: assert property (@(posedge clk) disable iff (!arst_n)
		32'(head_q) < MAX_SENTENCE)
		else $error("window head out of range");

endmodule

`default_nettype wire

>>> tb/sv/tb_start_pattern_fixed_length_framer.sv
`timescale 1ns / 1ps
// Testbench for start_pattern_fixed_length_framer: directed and random byte streams are
// framed by an in-bench predictor and every sentence byte is checked field by field.
// Depends on spflf_pkg and the framer RTL.

module tb_start_pattern_fixed_length_framer
	import spflf_pkg::*;
();

	localparam int SENT_MAX      = 64;
	localparam int PAT_MAX       = 8;
	localparam int RANDOM_ITEMS  = 310;
	localparam int MAX_GAP       = 8;
	localparam int SETTLE_CYCLES = 200;
	localparam int DRAIN_LIMIT   = 50000;
	localparam int CYCLE_LIMIT   = 1000000;
	localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

	typedef struct packed {
		logic [7:0]  data;
		logic [31:0] stamp;
	} rx_byte_t;

	typedef struct packed {
		logic [7:0]  data;
		logic [31:0] stamp;
		logic [5:0]  pos;
		logic        last;
	} sentence_beat_t;

	logic                 clk = 1'b0;
	logic                 arst_n = 1'b0;
	logic                 cfg_valid = 1'b0;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index = '0;
	logic [63:0]          cfg_data = '0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [7:0]           data_byte = '0;
	logic [31:0]          rx_time = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [7:0]           sentence_byte;
	logic [31:0]          sentence_time;
	logic [5:0]           byte_index;
	logic                 last_byte;

	// predictor copy of the registers and the window
	logic        rx_on = 1'b0;
	logic [3:0]  pat_len = 4'd1;
	logic [63:0] pat = '0;
	logic [6:0]  sent_len = 7'd1;
	logic [7:0]  win_data [SENT_MAX];
	logic [31:0] win_stamp [SENT_MAX];
	int          win_fill = 0;

	rx_byte_t       rx_backlog [$];
	sentence_beat_t due_beats [$];
	int queued_count = 0;
	int taken_count = 0;
	int mismatch_count = 0;
	int cycle_count = 0;
	int in_wait = 0;
	int out_hold = 0;
	bit in_calm = 1'b0;
	bit out_calm = 1'b0;

	start_pattern_fixed_length_framer u_top (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.data_byte    (data_byte),
		.rx_time      (rx_time),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.sentence_byte(sentence_byte),
		.sentence_time(sentence_time),
		.byte_index   (byte_index),
		.last_byte    (last_byte)
	);

	initial begin
		forever #4 clk = ~clk;
	end

	function automatic int pat_len_eff();
		if (pat_len == 0) return 1;
		return (pat_len > PAT_MAX) ? PAT_MAX : int'(pat_len);
	endfunction

	function automatic int sent_len_eff();
		if (sent_len == 0) return 1;
		return (sent_len > SENT_MAX) ? SENT_MAX : int'(sent_len);
	endfunction

	function automatic logic [7:0] pat_byte(input int i);
		return pat[8*i +: 8];
	endfunction

	function automatic logic [7:0] rand_byte();
		return 8'($urandom);
	endfunction

	// mostly random, now and then the extremes
	function automatic logic [31:0] rand_stamp();
		case ($urandom_range(0, 15))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	function automatic int draw_gap(input bit calm);
		return calm ? 0 : $urandom_range(0, MAX_GAP);
	endfunction

	task automatic report_mismatch(input string what);
		mismatch_count++;
		if (mismatch_count <= 40)
			$display("[%0t] mismatch: %s", $time, what);
	endtask

	// Frame one accepted byte and queue the sentence bytes it completes.
	task automatic frame_rx_byte(input logic [7:0] b, input logic [31:0] t);
		int slen;
		int plen;
		int k;
		int j;
		bit hit;
		sentence_beat_t beat;
		slen = sent_len_eff();
		plen = pat_len_eff();
		if (!rx_on) return;
		if (win_fill >= slen) win_fill = 0;
		if (win_fill == 0 && b != pat_byte(0)) return;
		win_data[win_fill] = b;
		win_stamp[win_fill] = t;
		win_fill++;
		if (win_fill < slen) return;
		hit = (slen >= plen);
		for (k = 0; hit && k < plen; k++)
			if (win_data[k] != pat_byte(k)) hit = 1'b0;
		if (!hit) begin
			// drop the front byte, slide to the next start byte
			k = 1;
			while (k < win_fill && win_data[k] != pat_byte(0)) k++;
			for (j = 0; j + k < win_fill; j++) begin
				win_data[j] = win_data[j+k];
				win_stamp[j] = win_stamp[j+k];
			end
			win_fill = (k >= win_fill) ? 0 : win_fill - k;
			return;
		end
		for (k = 0; k < slen; k++) begin
			beat = {win_data[k], win_stamp[0], 6'(k), k == slen - 1};
			due_beats.push_back(beat);
		end
		win_fill = 0;
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [63:0] value);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_RECEIVE_ENABLE: rx_on = value[0];
			REG_PATTERN_LENGTH: begin
				pat_len = value[3:0];
				win_fill = 0;
			end
			REG_START_PATTERN: begin
				pat = value;
				win_fill = 0;
			end
			REG_SENTENCE_LENGTH: begin
				sent_len = value[6:0];
				win_fill = 0;
			end
			default: ;
		endcase
	endtask

	task automatic queue_byte(input logic [7:0] b, input logic [31:0] t);
		rx_backlog.push_back({b, t});
		queued_count++;
	endtask

	// Wait until every item is taken and every sentence byte is out, then let a
	// mismatch rescan finish before touching the registers.
	task automatic settle();
		int waited;
		waited = 0;
		while (taken_count != queued_count) @(posedge clk);
		while (due_beats.size() != 0 && waited < DRAIN_LIMIT) begin
			@(posedge clk);
			waited++;
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// byte driver
	always @(posedge clk or negedge arst_n) begin : drive_rx
		rx_byte_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
			in_wait <= 0;
		end else begin
			if (in_valid && !in_stall) begin
				frame_rx_byte(data_byte, rx_time);
				taken_count++;
			end
			if (!in_valid || !in_stall) begin
				if (in_wait > 0) begin
					in_valid <= 1'b0;
					in_wait <= in_wait - 1;
				end else if (rx_backlog.size() > 0) begin
					nxt = rx_backlog.pop_front();
					in_valid <= 1'b1;
					data_byte <= nxt.data;
					rx_time <= nxt.stamp;
					if ($urandom_range(0, 19) == 0) in_calm = !in_calm;
					in_wait <= draw_gap(in_calm);
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// sentence monitor
	always @(posedge clk or negedge arst_n) begin : watch_sentences
		sentence_beat_t want;
		if (!arst_n) begin
			out_stall <= 1'b0;
			out_hold = 0;
		end else begin
			if (out_valid && !out_stall) begin
				if (due_beats.size() == 0) begin
					report_mismatch($sformatf("unexpected sentence byte %02h index %0d",
						sentence_byte, byte_index));
				end else begin
					want = due_beats.pop_front();
					if (sentence_byte !== want.data)
						report_mismatch($sformatf("sentence_byte at %0d: got %02h want %02h",
							want.pos, sentence_byte, want.data));
					if (sentence_time !== want.stamp)
						report_mismatch($sformatf("sentence_time at %0d: got %08h want %08h",
							want.pos, sentence_time, want.stamp));
					if (byte_index !== want.pos)
						report_mismatch($sformatf("byte_index: got %0d want %0d",
							byte_index, want.pos));
					if (last_byte !== want.last)
						report_mismatch($sformatf("last_byte at %0d: got %b want %b",
							want.pos, last_byte, want.last));
				end
				if ($urandom_range(0, 19) == 0) out_calm = !out_calm;
				out_hold = draw_gap(out_calm);
			end else if (out_hold > 0) begin
				out_hold--;
			end
			out_stall <= (out_hold > 0);
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	initial begin : stimulus
		int phase;
		int chunks;
		int c;
		int k;
		int n;
		int plen;
		int slen;
		int pick;
		int random_sent;
		logic [63:0] pv;
		random_sent = 0;
		phase = 0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// receiving is off after reset: ignore everything
		queue_byte(8'h00, 32'h0000_0000);
		queue_byte(8'hFF, 32'hFFFF_FFFF);
		settle();

		// reset lengths and pattern: every 0x00 is a one-byte sentence
		write_reg(REG_RECEIVE_ENABLE, 64'd1);
		queue_byte(8'h00, 32'hFFFF_FFFF);
		queue_byte(8'hFF, 32'h0000_0000);
		queue_byte(8'h00, 32'h0000_1234);
		settle();

		// zero lengths act as one
		write_reg(REG_PATTERN_LENGTH, 64'd0);
		write_reg(REG_SENTENCE_LENGTH, 64'd0);
		write_reg(REG_START_PATTERN, 64'hFFFF_FFFF_FFFF_FFFF);
		queue_byte(8'hFF, 32'h8000_0000);
		queue_byte(8'h7F, 32'h7FFF_FFFF);
		settle();

		// pattern longer than the sentence: never emits
		write_reg(REG_PATTERN_LENGTH, 64'd15);
		write_reg(REG_SENTENCE_LENGTH, 64'd3);
		repeat (4) queue_byte(8'hFF, rand_stamp());
		settle();

		// false start, then resync onto the real one
		write_reg(REG_START_PATTERN, 64'h0000_0000_0000_CDAB);
		write_reg(REG_PATTERN_LENGTH, 64'd2);
		write_reg(REG_SENTENCE_LENGTH, 64'd5);
		queue_byte(8'hAB, 32'h0000_0010);
		queue_byte(8'hAB, 32'h0000_0011);
		queue_byte(8'hCD, 32'h0000_0012);
		queue_byte(8'h11, 32'h0000_0013);
		queue_byte(8'h22, 32'h0000_0014);
		queue_byte(8'h33, 32'h0000_0015);
		settle();

		// partial window survives disable and a write to an unused index
		queue_byte(8'hAB, 32'h0000_0100);
		queue_byte(8'hCD, 32'h0000_0101);
		queue_byte(8'h44, 32'h0000_0102);
		settle();
		write_reg(REG_RECEIVE_ENABLE, 64'd0);
		write_reg(REG_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF);
		queue_byte(8'h55, 32'h0000_0103);
		settle();
		write_reg(REG_RECEIVE_ENABLE, 64'd1);
		queue_byte(8'h66, 32'h0000_0104);
		queue_byte(8'h77, 32'h0000_0105);
		settle();

		while (random_sent < RANDOM_ITEMS) begin
			if (phase > 1 && $urandom_range(0, 9) == 0) begin
				write_reg(REG_RECEIVE_ENABLE, 64'd0);
				repeat ($urandom_range(1, 5)) queue_byte(rand_byte(), rand_stamp());
				settle();
				write_reg(REG_RECEIVE_ENABLE, 64'd1);
			end
			pick = $urandom_range(0, 99);
			if (phase == 0) begin
				write_reg(REG_PATTERN_LENGTH, 64'd8);
				write_reg(REG_SENTENCE_LENGTH, 64'd127);
			end else if (phase == 1) begin
				write_reg(REG_PATTERN_LENGTH, 64'd15);
				write_reg(REG_SENTENCE_LENGTH, 64'd12);
			end else begin
				write_reg(REG_PATTERN_LENGTH,
					(pick < 70) ? $urandom_range(1, 3) : $urandom_range(0, 15));
				pick = $urandom_range(0, 99);
				write_reg(REG_SENTENCE_LENGTH, (pick < 4) ? 64 :
					(pick < 7) ? 0 : $urandom_range(1, 12));
			end
			pv = {$urandom, $urandom};
			// repeated start byte stresses the rescan
			if ($urandom_range(0, 3) == 0) pv[15:8] = pv[7:0];
			write_reg(REG_START_PATTERN, pv);
			plen = pat_len_eff();
			slen = sent_len_eff();
			chunks = (phase == 0) ? 2 : $urandom_range(3, 8);
			for (c = 0; c < chunks; c++) begin
				pick = $urandom_range(0, 99);
				if (pick < 65 || (phase == 0 && c == 0)) begin
					for (k = 0; k < slen; k++)
						queue_byte((k < plen) ? pat_byte(k) :
							($urandom_range(0, 4) == 0) ? pat_byte(0) : rand_byte(),
							rand_stamp());
					random_sent += slen;
				end else if (pick < 80) begin
					n = $urandom_range(1, plen);
					for (k = 0; k < n; k++) queue_byte(pat_byte(k), rand_stamp());
					random_sent += n;
				end else begin
					n = $urandom_range(1, 4);
					for (k = 0; k < n; k++)
						queue_byte($urandom_range(0, 1) ? pat_byte(0) : rand_byte(),
							rand_stamp());
					random_sent += n;
				end
			end
			settle();
			phase++;
		end

		if (due_beats.size() != 0)
			report_mismatch($sformatf("%0d sentence bytes never arrived", due_beats.size()));
		if (mismatch_count == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
